### sv/chsc_pkg.sv
package chsc_pkg;

	// ADC range and hit length limits
	localparam int unsigned ADC_FULL    = 1024;
	localparam int unsigned MAX_SAMPLES = 32;

	// Field and register widths
	localparam int unsigned CellW  = 64;
	localparam int unsigned AdcW   = 10;
	localparam int unsigned ToaW   = 10;
	localparam int unsigned StampW = 16;
	localparam int unsigned FbW    = 48;
	localparam int unsigned CoefW  = 32;
	localparam int unsigned AmpW   = 20;
	localparam int unsigned HitTW  = 32;
	localparam int unsigned CntW   = 6;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 32;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] RegDualGain   = 3'd0;
	localparam logic [CfgIdxW-1:0] RegCoefSingle = 3'd1;
	localparam logic [CfgIdxW-1:0] RegCoefHigh   = 3'd2;
	localparam logic [CfgIdxW-1:0] RegCoefLow    = 3'd3;
	localparam logic [CfgIdxW-1:0] RegPedestal   = 3'd4;
	localparam logic [CfgIdxW-1:0] RegAmpMax     = 3'd5;
	localparam logic [CfgIdxW-1:0] RegToaLsb     = 3'd6;
	localparam logic [CfgIdxW-1:0] RegWindow     = 3'd7;

endpackage

### sv/chsc_in_if.sv
interface chsc_in_if;
	import chsc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CellW-1:0]         cell_id;
	logic [AdcW-1:0]          main_adc;
	logic [AdcW-1:0]          low_gain_adc;
	logic [ToaW-1:0]          arrival;
	logic [ToaW-1:0]          hit_phase;
	logic [StampW-1:0]        hit_stamp;
	logic signed [FbW-1:0]    fallback_time;
	logic                     last_sample;

	modport source (
		output valid, cell_id, main_adc, low_gain_adc, arrival, hit_phase,
			hit_stamp, fallback_time, last_sample,
		input  ready
	);

	modport sink (
		input  valid, cell_id, main_adc, low_gain_adc, arrival, hit_phase,
			hit_stamp, fallback_time, last_sample,
		output ready
	);

endinterface

### sv/chsc_out_if.sv
interface chsc_out_if;
	import chsc_pkg::*;

	logic             valid;
	logic             ready;
	logic [CellW-1:0] out_cell_id;
	logic [AmpW-1:0]  amplitude;
	logic [HitTW-1:0] hit_time;

	modport source (
		output valid, out_cell_id, amplitude, hit_time,
		input  ready
	);

	modport sink (
		input  valid, out_cell_id, amplitude, hit_time,
		output ready
	);

endinterface

### sv/calorimeter_hit_sample_combiner_unit.sv
// Combines the readout samples of one channel hit into a single result. One
// sample transaction is taken every clock; samples are scaled by the configured
// Q16.16 gain coefficient and summed, and the first sample with a nonzero
// arrival count fixes the hit time, else the last sample's fallback time does.
// The sample marked last closes the hit and yields one result transaction (cell
// id, rounded and clamped amplitude, rounded and saturated time) on the output.
// The datapath is a four-register pipeline: input register, product register
// (gain and time multipliers), hit accumulators with a closed-hit register, and
// the output register where rounding and clamping land. Every stage has its
// own ready, so samples keep flowing while a finished result waits to be taken;
// the input stalls only once the stages behind a pending result are full.
// Configuration registers are written through the plain write port and must
// only change while no hit is in flight.
module calorimeter_hit_sample_combiner_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [chsc_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [chsc_pkg::CfgDataW-1:0]   cfg_data,
	chsc_in_if.sink                         hit_in,
	chsc_out_if.source                      hit_out
);
	import chsc_pkg::*;

	// Configuration registers
	logic             dual_gain_q;
	logic [CoefW-1:0] coef_single_q;
	logic [CoefW-1:0] coef_high_q;
	logic [CoefW-1:0] coef_low_q;
	logic [AmpW-1:0]  pedestal_q;
	logic [AmpW-1:0]  amp_max_q;
	logic [CoefW-1:0] toa_lsb_q;
	logic [CoefW-1:0] window_q;

	// Stage 1: accepted sample
	logic                  v_s1;
	logic [CellW-1:0]      cell_s1;
	logic [AdcW-1:0]       main_s1;
	logic [AdcW-1:0]       low_s1;
	logic [ToaW-1:0]       arr_s1;
	logic [ToaW-1:0]       phase_s1;
	logic [StampW-1:0]     stamp_s1;
	logic signed [FbW-1:0] fb_s1;
	logic                  last_s1;

	// Sample index within the hit, tracked as samples enter stage 2
	logic [CntW-1:0] cnt_q;

	// Stage 2: products
	logic                  v_s2;
	logic [CellW-1:0]      cell_s2;
	logic signed [FbW-1:0] fb_s2;
	logic                  last_s2;
	logic                  arr_nz_s2;
	logic [AdcW+CoefW-1:0] term_s2;
	logic signed [43:0]    tp1_s2;
	logic [48:0]           tp2_s2;

	// Hit accumulators
	logic [47:0]        energy_q;
	logic               found_q;
	logic signed [50:0] time_q;

	// Stage 3: closed hit
	logic               v_s3;
	logic [CellW-1:0]   cell_s3;
	logic [47:0]        sum_s3;
	logic signed [50:0] time_s3;

	// Output register
	logic             out_v_q;
	logic [CellW-1:0] out_cell_q;
	logic [AmpW-1:0]  out_amp_q;
	logic [HitTW-1:0] out_time_q;

	// Handshake between stages
	logic rdy_out, rdy3, rdy2, rdy1;
	logic fire12, fire2, fire3;

	assign rdy_out = !out_v_q || hit_out.ready;
	assign rdy3    = !v_s3 || rdy_out;
	// A non-last sample only folds into the accumulators, so it never waits
	assign rdy2    = !v_s2 || !last_s2 || rdy3;
	assign rdy1    = !v_s1 || rdy2;
	assign fire12  = v_s1 && rdy2;
	assign fire2   = v_s2 && (!last_s2 || rdy3);
	assign fire3   = v_s3 && rdy_out;

	assign hit_in.ready = rdy1;

	// Gain selection and products for stage 2
	logic [AdcW-1:0]       gain_adc;
	logic [CoefW-1:0]      gain_coef;
	logic [AdcW+CoefW-1:0] term_d;
	logic [ToaW:0]         dphase;
	logic signed [43:0]    tp1_d;
	logic [16:0]           widx;
	logic [48:0]           tp2_d;

	always_comb begin
		if (!dual_gain_q) begin
			gain_adc  = main_s1;
			gain_coef = coef_single_q;
		end else if ({7'b0, main_s1} < 17'(ADC_FULL - 1)) begin
			gain_adc  = main_s1;
			gain_coef = coef_high_q;
		end else begin
			gain_adc  = low_s1;
			gain_coef = coef_low_q;
		end
		term_d = {{CoefW{1'b0}}, gain_adc} * {{AdcW{1'b0}}, gain_coef};
		dphase = {1'b0, phase_s1} - {1'b0, arr_s1};
		tp1_d  = $signed({{33{dphase[ToaW]}}, dphase}) * $signed({12'b0, toa_lsb_q});
		widx   = {1'b0, stamp_s1} + {11'b0, cnt_q};
		tp2_d  = {32'b0, widx} * {17'b0, window_q};
	end

	// Accumulator next values for stage 2 leaving
	logic [48:0]        sum_ext;
	logic [47:0]        sum_nx;
	logic signed [50:0] tv;
	logic signed [50:0] time_close;

	always_comb begin
		sum_ext = {1'b0, energy_q} + {7'b0, term_s2};
		// saturate the energy sum rather than wrap
		sum_nx  = sum_ext[48] ? {48{1'b1}} : sum_ext[47:0];
		tv      = $signed({{7{tp1_s2[43]}}, tp1_s2}) + $signed({2'b0, tp2_s2});
		if (found_q) begin
			time_close = time_q;
		end else if (arr_nz_s2) begin
			time_close = tv;
		end else begin
			time_close = $signed({{3{fb_s2[FbW-1]}}, fb_s2});
		end
	end

	// Rounding and clamping for the output register
	logic [48:0]        amp_sum;
	logic [32:0]        amp_full;
	logic [AmpW-1:0]    amp_d;
	logic [50:0]        t_rnd;
	logic [34:0]        t_full;
	logic [HitTW-1:0]   time_d;

	always_comb begin
		amp_sum  = {13'b0, pedestal_q, 16'b0} + {1'b0, sum_s3} + 49'd32768;
		amp_full = amp_sum[48:16];
		amp_d    = (amp_full > {13'b0, amp_max_q}) ? amp_max_q : amp_full[AmpW-1:0];
		t_rnd    = {1'b0, time_s3[49:0]} + 51'd32768;
		t_full   = t_rnd[50:16];
		if (time_s3[50] || time_s3 == '0) begin
			// time at or below zero floors to zero
			time_d = '0;
		end else if (t_full[34:32] != 3'b0) begin
			time_d = {HitTW{1'b1}};
		end else begin
			time_d = t_full[HitTW-1:0];
		end
	end

	// Configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dual_gain_q   <= 1'b0;
			coef_single_q <= 32'd65536;
			coef_high_q   <= 32'd65536;
			coef_low_q    <= 32'd65536;
			pedestal_q    <= '0;
			amp_max_q     <= 20'd4095;
			toa_lsb_q     <= 32'd65536;
			window_q      <= 32'd65536;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				RegDualGain:   dual_gain_q   <= cfg_data[0];
				RegCoefSingle: coef_single_q <= cfg_data;
				RegCoefHigh:   coef_high_q   <= cfg_data;
				RegCoefLow:    coef_low_q    <= cfg_data;
				RegPedestal:   pedestal_q    <= cfg_data[AmpW-1:0];
				RegAmpMax:     amp_max_q     <= cfg_data[AmpW-1:0];
				RegToaLsb:     toa_lsb_q     <= cfg_data;
				RegWindow:     window_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control state: valids, sample index, accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			out_v_q  <= 1'b0;
			cnt_q    <= '0;
			energy_q <= '0;
			found_q  <= 1'b0;
			time_q   <= '0;
		end else begin
			if (rdy1) begin
				v_s1 <= hit_in.valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= fire2 && last_s2;
			end
			if (rdy_out) begin
				out_v_q <= v_s3;
			end
			// advance the sample index, saturating on long hits
			if (fire12) begin
				if (last_s1) begin
					cnt_q <= '0;
				end else if (cnt_q < CntW'(MAX_SAMPLES)) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (fire2) begin
				if (last_s2) begin
					energy_q <= '0;
					found_q  <= 1'b0;
					time_q   <= '0;
				end else begin
					energy_q <= sum_nx;
					if (!found_q && arr_nz_s2) begin
						time_q  <= tv;
						found_q <= 1'b1;
					end
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (hit_in.valid && rdy1) begin
			cell_s1  <= hit_in.cell_id;
			main_s1  <= hit_in.main_adc;
			low_s1   <= hit_in.low_gain_adc;
			arr_s1   <= hit_in.arrival;
			phase_s1 <= hit_in.hit_phase;
			stamp_s1 <= hit_in.hit_stamp;
			fb_s1    <= hit_in.fallback_time;
			last_s1  <= hit_in.last_sample;
		end
		if (fire12) begin
			cell_s2   <= cell_s1;
			fb_s2     <= fb_s1;
			last_s2   <= last_s1;
			arr_nz_s2 <= (arr_s1 != '0);
			term_s2   <= term_d;
			tp1_s2    <= tp1_d;
			tp2_s2    <= tp2_d;
		end
		if (fire2 && last_s2) begin
			cell_s3 <= cell_s2;
			sum_s3  <= sum_nx;
			time_s3 <= time_close;
		end
		if (fire3) begin
			out_cell_q <= cell_s3;
			out_amp_q  <= amp_d;
			out_time_q <= time_d;
		end
	end

	assign hit_out.valid       = out_v_q;
	assign hit_out.out_cell_id = out_cell_q;
	assign hit_out.amplitude   = out_amp_q;
	assign hit_out.hit_time    = out_time_q;

endmodule
